/* rtl/core/rrcb_pkg.sv */
// ----------------------------------------------------------------------------
// rrcb_pkg
// Shared types, register indexes and helpers for the rounded rectangle
// coverage and blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rrcb_pkg;

    localparam int MAX_CANVAS_DEF = 4096;
    localparam int NUM_STAGES     = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT     = 3'd0,
        CFG_RECT_TOP      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOR    = 3'd5,
        CFG_CANVAS_WIDTH  = 3'd6,
        CFG_CANVAS_HEIGHT = 3'd7
    } cfg_idx_t;

    // stage 1 request: pixel plus core box bounds in pixel units
    typedef struct packed {
        logic [11:0]        px;
        logic [11:0]        py;
        logic [31:0]        dest;
        logic               in_rect;
        logic signed [14:0] lc;
        logic signed [14:0] rc;
        logic signed [14:0] tc;
        logic signed [14:0] bc;
        logic [11:0]        rad;
    } s1_t;

    // coverage result handed to the blend stages
    typedef struct packed {
        logic [31:0] dest;
        logic [4:0]  cov;
        logic        in_rect;
    } cov_res_t;

    function automatic logic [2:0] cnt4(input logic [3:0] v);
        cnt4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
    endfunction

    // floor(v / 255), exact while the quotient fits in 8 bits
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        div255 = t[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rrcb_coverage.sv */
// ----------------------------------------------------------------------------
// rrcb_coverage
// Stages 2..5: per-sample distance to the core box, squares, radius test
// and the 16-sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcb_coverage
(
    input  wire logic            clk,
    input  wire logic [3:0]      load,
    input  wire rrcb_pkg::s1_t   s1,
    output rrcb_pkg::cov_res_t   res
);

    // stage 2
    logic [16:0] dxa_reg  [4];
    logic [16:0] dya_reg  [4];
    logic [16:0] dxa_next [4];
    logic [16:0] dya_next [4];
    logic [11:0] rad2_reg;
    logic [31:0] dest2_reg;
    logic        in2_reg;

    // stage 3
    logic [33:0] sqx_reg [4];
    logic [33:0] sqy_reg [4];
    logic [29:0] rsq_reg;
    logic [31:0] dest3_reg;
    logic        in3_reg;

    // stage 4
    logic [15:0] hit_reg;
    logic [15:0] hit_next;
    logic [31:0] dest4_reg;
    logic        in4_reg;

    // stage 5
    rrcb_pkg::cov_res_t res_reg;
    logic [4:0]         cov_next;

    function automatic logic [16:0] axis_dist(input logic [11:0] p, input logic [1:0] s,
                                              input logic signed [14:0] lo,
                                              input logic signed [14:0] hi);
        logic signed [18:0] x;
        logic signed [18:0] lo8;
        logic signed [18:0] hi8;
        logic signed [18:0] dlo;
        logic signed [18:0] dhi;
        logic signed [18:0] d;
        logic signed [18:0] a;
        x   = $signed({4'b0000, p, s, 1'b1});
        lo8 = $signed({lo[14], lo, 3'b000});
        hi8 = $signed({hi[14], hi, 3'b000});
        dlo = x - lo8;
        dhi = x - hi8;
        // low bound wins when the box is inverted
        if (dlo[18])
            d = dlo;
        else if (!dhi[18] && dhi != 19'sd0)
            d = dhi;
        else
            d = 19'sd0;
        a = d[18] ? -d : d;
        axis_dist = a[16:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dxa_next[i] = axis_dist(s1.px, 2'(i), s1.lc, s1.rc);
            dya_next[i] = axis_dist(s1.py, 2'(i), s1.tc, s1.bc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                dxa_reg[i] <= dxa_next[i];
                dya_reg[i] <= dya_next[i];
            end
            rad2_reg  <= s1.rad;
            dest2_reg <= s1.dest;
            in2_reg   <= s1.in_rect;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            for (int i = 0; i < 4; i++)
            begin
                sqx_reg[i] <= 34'(dxa_reg[i]) * 34'(dxa_reg[i]);
                sqy_reg[i] <= 34'(dya_reg[i]) * 34'(dya_reg[i]);
            end
            rsq_reg   <= 30'({rad2_reg, 3'b000}) * 30'({rad2_reg, 3'b000});
            dest3_reg <= dest2_reg;
            in3_reg   <= in2_reg;
        end
    end

    always_comb
    begin
        for (int sy = 0; sy < 4; sy++)
        begin
            for (int sx = 0; sx < 4; sx++)
            begin
                hit_next[sy*4 + sx] = (35'(sqx_reg[sx]) + 35'(sqy_reg[sy])) <= 35'(rsq_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            hit_reg   <= hit_next;
            dest4_reg <= dest3_reg;
            in4_reg   <= in3_reg;
        end
    end

    always_comb
    begin
        cov_next = 5'(rrcb_pkg::cnt4(hit_reg[3:0]))  + 5'(rrcb_pkg::cnt4(hit_reg[7:4]))
                 + 5'(rrcb_pkg::cnt4(hit_reg[11:8])) + 5'(rrcb_pkg::cnt4(hit_reg[15:12]));
        if (!in4_reg)
            cov_next = 5'd0;
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            res_reg.dest    <= dest4_reg;
            res_reg.cov     <= cov_next;
            res_reg.in_rect <= in4_reg;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* rtl/core/rrcb_blend.sv */
// ----------------------------------------------------------------------------
// rrcb_blend
// Stages 6..8: coverage-scaled source, source-over products, divide by 255
// with saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcb_blend
(
    input  wire logic               clk,
    input  wire logic [2:0]         load,
    input  wire rrcb_pkg::cov_res_t res,
    input  wire logic [31:0]        fill_color,
    output logic [31:0]             out_pixel,
    output logic                    pixel_written,
    output logic [4:0]              sample_coverage
);

    // stage 6
    logic [7:0]  src6_reg  [4];
    logic [7:0]  src6_next [4];
    logic [7:0]  inv6_reg;
    logic [31:0] dest6_reg;
    logic [4:0]  cov6_reg;
    logic        wr6_reg;

    // stage 7
    logic [7:0]  src7_reg  [4];
    logic [15:0] prod7_reg [4];
    logic [31:0] dest7_reg;
    logic [4:0]  cov7_reg;
    logic        wr7_reg;

    // stage 8
    logic [31:0] blend_next;
    logic [31:0] out_pixel_reg;
    logic        pixel_written_reg;
    logic [4:0]  sample_coverage_reg;

    always_comb
    begin
        logic [12:0] p;
        for (int c = 0; c < 4; c++)
        begin
            p = 13'(fill_color[8*c +: 8]) * 13'(res.cov);
            src6_next[c] = p[11:4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int c = 0; c < 4; c++)
                src6_reg[c] <= src6_next[c];
            inv6_reg  <= 8'hFF - src6_next[3];
            dest6_reg <= res.dest;
            cov6_reg  <= res.cov;
            wr6_reg   <= res.in_rect && (res.cov != 5'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            for (int c = 0; c < 4; c++)
            begin
                src7_reg[c]  <= src6_reg[c];
                prod7_reg[c] <= 16'(dest6_reg[8*c +: 8]) * 16'(inv6_reg);
            end
            dest7_reg <= dest6_reg;
            cov7_reg  <= cov6_reg;
            wr7_reg   <= wr6_reg;
        end
    end

    always_comb
    begin
        logic [8:0] v;
        for (int c = 0; c < 4; c++)
        begin
            v = 9'(src7_reg[c]) + 9'(rrcb_pkg::div255(prod7_reg[c]));
            blend_next[8*c +: 8] = v[8] ? 8'hFF : v[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            out_pixel_reg       <= wr7_reg ? blend_next : dest7_reg;
            pixel_written_reg   <= wr7_reg;
            sample_coverage_reg <= cov7_reg;
        end
    end

    assign out_pixel       = out_pixel_reg;
    assign pixel_written   = pixel_written_reg;
    assign sample_coverage = sample_coverage_reg;

endmodule

`default_nettype wire

/* rtl/core/rounded_rect_coverage_blend.sv */
// ----------------------------------------------------------------------------
// rounded_rect_coverage_blend
// Anti-aliased rounded rectangle drawn over a stream of destination pixels:
// 4x4 supersampled coverage, then a source-over blend of the fill color.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  input   | in_valid / in_stall   | pixel_x, pixel_y, dest_pixel
//  output  | out_valid / out_stall | out_pixel, pixel_written, sample_coverage
//  config  | cfg_we, no read-back  | cfg_index, cfg_data
//
//  One pixel per clock sustained while out_stall is low, through 8 register
//  stages, the deepest being the 17x17 distance squarers in stage 3.
//  Each stage advances when it is empty or the next one advances, so bubbles
//  collapse and in_stall only rises when every stage holds a request.
//  rst_n clears the valid bits and resets the config registers (canvas size
//  to 4096, the rest to zero); payload is not reset.
`default_nettype none

module rounded_rect_coverage_blend
#(
    parameter int MAX_CANVAS = rrcb_pkg::MAX_CANVAS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [11:0]                     pixel_x,
    input  wire logic [11:0]                     pixel_y,
    input  wire logic [31:0]                     dest_pixel,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [31:0]                          out_pixel,
    output logic                                 pixel_written,
    output logic [4:0]                           sample_coverage,

    input  wire logic                            cfg_we,
    input  wire logic [rrcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rrcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG  = rrcb_pkg::NUM_STAGES;
    // canvas compare width: fits the register and MAX_CANVAS itself
    localparam int CAN_W = ($clog2(MAX_CANVAS + 1) > 13) ? $clog2(MAX_CANVAS + 1) : 13;

    // config registers
    logic signed [12:0] rect_left_reg;
    logic signed [12:0] rect_top_reg;
    logic [12:0]        rect_width_reg;
    logic [12:0]        rect_height_reg;
    logic [11:0]        corner_radius_reg;
    logic [31:0]        fill_color_reg;
    logic [12:0]        canvas_width_reg;
    logic [12:0]        canvas_height_reg;

    // pipeline control
    logic [NSTG-1:0]    valid_reg;
    logic [NSTG-1:0]    load;

    // stage 1
    rrcb_pkg::s1_t      s1_reg;
    rrcb_pkg::s1_t      s1_next;
    rrcb_pkg::cov_res_t cov_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
            fill_color_reg    <= '0;
            canvas_width_reg  <= 13'd4096;
            canvas_height_reg <= 13'd4096;
        end
        else if (cfg_we)
        begin
            unique case (rrcb_pkg::cfg_idx_t'(cfg_index))
                rrcb_pkg::CFG_RECT_LEFT:     rect_left_reg     <= $signed(cfg_data[12:0]);
                rrcb_pkg::CFG_RECT_TOP:      rect_top_reg      <= $signed(cfg_data[12:0]);
                rrcb_pkg::CFG_RECT_WIDTH:    rect_width_reg    <= cfg_data[12:0];
                rrcb_pkg::CFG_RECT_HEIGHT:   rect_height_reg   <= cfg_data[12:0];
                rrcb_pkg::CFG_CORNER_RADIUS: corner_radius_reg <= cfg_data[11:0];
                rrcb_pkg::CFG_FILL_COLOR:    fill_color_reg    <= cfg_data[31:0];
                rrcb_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[12:0];
                rrcb_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // stage i loads when empty or when stage i+1 loads; last stage faces out_stall
    always_comb
    begin
        load[NSTG-1] = !valid_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
            load[i] = !valid_reg[i] || load[i+1];
    end

    assign in_stall  = !load[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (load[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
                if (load[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: rectangle/canvas test and core box bounds (pixel units)
    always_comb
    begin
        logic signed [14:0] left_s;
        logic signed [14:0] top_s;
        logic signed [14:0] rad_s;
        logic signed [14:0] right_s;
        logic signed [14:0] bottom_s;
        logic signed [14:0] px_s;
        logic signed [14:0] py_s;
        logic [CAN_W-1:0]   cw_eff;
        logic [CAN_W-1:0]   ch_eff;
        left_s   = 15'(rect_left_reg);
        top_s    = 15'(rect_top_reg);
        rad_s    = $signed({3'b000, corner_radius_reg});
        right_s  = left_s + $signed({2'b00, rect_width_reg});
        bottom_s = top_s + $signed({2'b00, rect_height_reg});
        px_s     = $signed({3'b000, pixel_x});
        py_s     = $signed({3'b000, pixel_y});
        cw_eff   = (CAN_W'(canvas_width_reg) < CAN_W'(MAX_CANVAS))
                 ? CAN_W'(canvas_width_reg) : CAN_W'(MAX_CANVAS);
        ch_eff   = (CAN_W'(canvas_height_reg) < CAN_W'(MAX_CANVAS))
                 ? CAN_W'(canvas_height_reg) : CAN_W'(MAX_CANVAS);

        s1_next.px      = pixel_x;
        s1_next.py      = pixel_y;
        s1_next.dest    = dest_pixel;
        s1_next.in_rect = (px_s >= left_s) && (px_s < right_s)
                       && (py_s >= top_s) && (py_s < bottom_s)
                       && (CAN_W'(pixel_x) < cw_eff) && (CAN_W'(pixel_y) < ch_eff);
        s1_next.lc      = left_s + rad_s;
        s1_next.rc      = right_s - rad_s;
        s1_next.tc      = top_s + rad_s;
        s1_next.bc      = bottom_s - rad_s;
        s1_next.rad     = corner_radius_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            s1_reg <= s1_next;
    end

    // stages 2..5
    rrcb_coverage u_cov
    (
        .clk  (clk),
        .load (load[4:1]),
        .s1   (s1_reg),
        .res  (cov_res)
    );

    // stages 6..8
    rrcb_blend u_blend
    (
        .clk             (clk),
        .load            (load[7:5]),
        .res             (cov_res),
        .fill_color      (fill_color_reg),
        .out_pixel       (out_pixel),
        .pixel_written   (pixel_written),
        .sample_coverage (sample_coverage)
    );

`ifndef NO_ASSERTIONS
    a_written_has_cov : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_written |-> sample_coverage != 5'd0)
        else $error("written pixel with zero coverage");

    a_cov_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_coverage <= 5'd16)
        else $error("coverage above 16");

    a_no_false_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> valid_reg == {NSTG{1'b1}} && out_stall)
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
